// ===== sv/ssplit_pkg.sv =====
// Shared types, constants and helpers for the string delimiter splitter.
`timescale 1ns / 1ps

package ssplit_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_SPLIT_MODE   = 2'd0;
  localparam logic [1:0] REG_DELIM_LENGTH = 2'd1;
  localparam logic [1:0] REG_DELIM_BYTES  = 2'd2;

  // Split modes
  localparam logic MODE_DELIM = 1'b0;
  localparam logic MODE_UTF8  = 1'b1;

  // Delimiter register holds at most this many bytes
  localparam int unsigned DELIM_REG_BYTES = 8;

  // Results one item can produce, and the width of a result pointer
  localparam int unsigned MAX_RES = 10;
  localparam int unsigned RES_W   = $clog2(MAX_RES);

  // UTF-8 lead byte thresholds
  localparam logic [7:0] UTF8_TWO_MIN   = 8'h80;
  localparam logic [7:0] UTF8_THREE_MIN = 8'hE0;
  localparam logic [7:0] UTF8_FOUR_MIN  = 8'hF0;

  // What follows the byte results of one item
  typedef struct packed {
    logic seg_end;  // one segment-end result after the bytes
    logic blank;    // one empty result that only carries string_done
    logic ends;     // item ended the string: flag the last result
  } tail_t;

  // Number of bytes that follow a lead byte
  function automatic logic [2:0] utf8_follow_count(input logic [7:0] lead);
    logic [2:0] cnt;
    if (lead < UTF8_TWO_MIN) begin
      cnt = 3'd0;
    end else if (lead < UTF8_THREE_MIN) begin
      cnt = 3'd1;
    end else if (lead < UTF8_FOUR_MIN) begin
      cnt = 3'd2;
    end else begin
      cnt = 3'd3;
    end
    return cnt;
  endfunction

endpackage

// ===== sv/ssplit_core.sv =====
// Single-pass item logic: window match, byte release and segment ends for one item.
`timescale 1ns / 1ps

module ssplit_core #(
  parameter int unsigned DELIM_MAX = 8,
  localparam int unsigned FILL_W = $clog2(DELIM_MAX + 1),
  localparam int unsigned SEQ_W  = $clog2(DELIM_MAX + 2)
) (
  input  logic                  split_mode,
  input  logic [3:0]            delim_length,
  input  logic [63:0]           delim_bytes,
  input  logic [7:0]            win [DELIM_MAX],
  input  logic [FILL_W-1:0]     fill,
  input  logic                  seg_has,
  input  logic [2:0]            cbl,
  input  logic [7:0]            data_byte,
  input  logic                  byte_present,
  input  logic                  string_end,
  output logic [7:0]            seq [DELIM_MAX+1],
  output logic [SEQ_W-1:0]      nb,
  output ssplit_pkg::tail_t     tail,
  output logic [7:0]            win_nxt [DELIM_MAX],
  output logic [FILL_W-1:0]     fill_nxt,
  output logic                  seg_has_nxt,
  output logic [2:0]            cbl_nxt
);

  localparam int unsigned CAP = (DELIM_MAX < ssplit_pkg::DELIM_REG_BYTES) ?
                                DELIM_MAX : ssplit_pkg::DELIM_REG_BYTES;

  logic [3:0]       len_eff;
  logic [7:0]       s [DELIM_MAX+1];
  logic [SEQ_W-1:0] seq_len;
  logic [SEQ_W-1:0] kk;
  logic [SEQ_W-1:0] rem;
  logic             match;
  logic [2:0]       cbl_new;

  assign len_eff = (delim_length > 4'(CAP)) ? 4'(CAP) : delim_length;
  assign seq_len = SEQ_W'(fill) + SEQ_W'(byte_present);

  // Window bytes followed by the new byte
  always_comb begin
    for (int i = 0; i < DELIM_MAX; i++) begin
      s[i] = (fill == FILL_W'(i)) ? data_byte : win[i];
    end
    s[DELIM_MAX] = data_byte;
  end

  // Smallest release count that leaves a delimiter prefix in the window
  always_comb begin
    logic [SEQ_W-1:0] slen;
    logic             okv;
    kk = seq_len;
    for (int k = DELIM_MAX; k >= 0; k--) begin
      okv  = (SEQ_W'(k) < seq_len);
      slen = seq_len - SEQ_W'(k);
      if (8'(slen) > 8'(len_eff)) begin
        okv = 1'b0;
      end
      for (int i = 0; i < CAP; i++) begin
        if (k + i <= DELIM_MAX) begin
          if (SEQ_W'(i) < slen && s[k+i] != delim_bytes[8*i +: 8]) begin
            okv = 1'b0;
          end
        end
      end
      if (okv) begin
        kk = SEQ_W'(k);
      end
    end
    if (!byte_present) begin
      kk = '0;
    end
  end

  assign rem     = seq_len - kk;
  assign match   = byte_present && (len_eff != 4'd0) && (8'(rem) == 8'(len_eff));
  assign cbl_new = !byte_present ? cbl :
                   (cbl == 3'd0) ? ssplit_pkg::utf8_follow_count(data_byte) : cbl - 3'd1;

  always_comb begin
    logic seg_mid;
    for (int i = 0; i <= DELIM_MAX; i++) begin
      seq[i] = s[i];
    end
    for (int i = 0; i < DELIM_MAX; i++) begin
      win_nxt[i] = s[i];
      for (int j = 1; j <= DELIM_MAX - i; j++) begin
        if (kk == SEQ_W'(j)) begin
          win_nxt[i] = s[i+j];
        end
      end
    end
    seg_mid      = 1'b0;
    tail.ends    = string_end;
    if (split_mode == ssplit_pkg::MODE_UTF8) begin
      seq[0]       = data_byte;
      nb           = SEQ_W'(byte_present);
      tail.seg_end = (byte_present && cbl_new == 3'd0) || (string_end && cbl_new != 3'd0);
      for (int i = 0; i < DELIM_MAX; i++) begin
        win_nxt[i] = win[i];
      end
      fill_nxt     = fill;
      seg_has_nxt  = seg_has;
      cbl_nxt      = cbl_new;
    end else begin
      nb           = (string_end && !match) ? seq_len : kk;
      seg_mid      = !match && (seg_has || nb != '0);
      tail.seg_end = match || (string_end && (len_eff == 4'd0 || seg_mid));
      fill_nxt     = match ? '0 : FILL_W'(rem);
      seg_has_nxt  = seg_mid;
      cbl_nxt      = cbl;
    end
    tail.blank = string_end && (nb == '0) && !tail.seg_end;
    // A string end clears the window fill, the segment flag and the character count
    if (string_end) begin
      fill_nxt    = '0;
      seg_has_nxt = 1'b0;
      cbl_nxt     = 3'd0;
    end
  end

endmodule

// ===== sv/ssplit_outbuf.sv =====
// Result buffer: holds the results of one item and sends them one beat per cycle while out_ready is high.
`timescale 1ns / 1ps

module ssplit_outbuf #(
  parameter int unsigned DELIM_MAX = 8,
  localparam int unsigned SEQ_W = $clog2(DELIM_MAX + 2)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [7:0]        seq_in [DELIM_MAX+1],
  input  logic [SEQ_W-1:0]  nb_in,
  input  ssplit_pkg::tail_t tail_in,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_byte_valid,
  output logic              out_segment_end,
  output logic              out_string_done
);

  localparam int unsigned RES_W = ssplit_pkg::RES_W;
  localparam int unsigned CMP_W = (SEQ_W + 1 > RES_W) ? SEQ_W + 1 : RES_W;

  logic [7:0]        seq_r [DELIM_MAX+1];
  logic [SEQ_W-1:0]  nb_r;
  ssplit_pkg::tail_t tail_r;
  logic [RES_W-1:0]  ptr_r, ptr_nxt;
  logic [RES_W-1:0]  last_r;
  logic              valid_r, valid_nxt;
  logic [CMP_W-1:0]  total;
  logic [CMP_W-1:0]  count;
  logic              is_byte;
  logic              at_last;

  assign total = CMP_W'(nb_in) + CMP_W'(tail_in.seg_end) + CMP_W'(tail_in.blank);
  assign count = (total > CMP_W'(ssplit_pkg::MAX_RES)) ? CMP_W'(ssplit_pkg::MAX_RES) : total;

  assign at_last = (ptr_r == last_r);
  assign free    = !valid_r || (out_ready && at_last);
  assign is_byte = CMP_W'(ptr_r) < CMP_W'(nb_r);

  always_comb begin
    out_byte = 8'h00;
    for (int j = 0; j <= DELIM_MAX; j++) begin
      if (is_byte && CMP_W'(ptr_r) == CMP_W'(j)) begin
        out_byte = seq_r[j];
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_byte_valid  = is_byte;
  assign out_segment_end = !is_byte && tail_r.seg_end;
  assign out_string_done = tail_r.ends && at_last;

  always_comb begin
    valid_nxt = valid_r;
    ptr_nxt   = ptr_r;
    if (valid_r && out_ready) begin
      if (at_last) begin
        valid_nxt = 1'b0;
      end else begin
        ptr_nxt = ptr_r + RES_W'(1);
      end
    end
    if (load) begin
      valid_nxt = (total != '0);
      ptr_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ptr_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seq_r  <= seq_in;
      nb_r   <= nb_in;
      tail_r <= tail_in;
      last_r <= RES_W'(count - CMP_W'(1));
    end
  end

endmodule

// ===== sv/string_delimiter_splitter.sv =====
// Top level of the string delimiter splitter: input register, split state and result buffer.
`timescale 1ns / 1ps

// Streams a string in one byte per beat (string_end on the last beat, byte_present
// low for an end-only beat) and returns it cut into segments: byte beats closed by a
// segment_end beat, with string_done on the last beat a string end causes. Mode 0
// splits on the configured delimiter (leftmost, non-overlapping matches); mode 1
// makes every UTF-8 character its own segment. Each input beat is registered, then
// resolved against the match window once the result buffer is free, into a burst of
// 0 to 10 results that the result buffer sends one beat per cycle while out_ready
// is high. A beat that yields at most one result therefore sustains one beat per
// cycle; a beat that yields more holds the input register until the single-beat
// result port has sent them (window flush at string end is the common case). The
// first result is registered in the result buffer behind the input register.
// Write configuration only between strings or while the block is idle; the new
// values apply from the next item.
module string_delimiter_splitter #(
  parameter int unsigned DELIM_MAX = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // string bytes in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_string_end,
  // segments out
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_segment_end,
  output logic        out_string_done
);

  localparam int unsigned FILL_W = $clog2(DELIM_MAX + 1);
  localparam int unsigned SEQ_W  = $clog2(DELIM_MAX + 2);

  // Configuration registers
  logic        split_mode_r;
  logic [3:0]  delim_length_r;
  logic [63:0] delim_bytes_r;

  // Input register
  logic        in_valid_r;
  logic [7:0]  data_byte_r;
  logic        byte_present_r;
  logic        string_end_r;

  // Split state
  logic [7:0]        win_r [DELIM_MAX];
  logic [FILL_W-1:0] fill_r;
  logic              seg_has_r;
  logic [2:0]        cbl_r;

  logic [7:0]        win_nxt [DELIM_MAX];
  logic [FILL_W-1:0] fill_nxt;
  logic              seg_has_nxt;
  logic [2:0]        cbl_nxt;

  logic [7:0]        seq [DELIM_MAX+1];
  logic [SEQ_W-1:0]  nb;
  ssplit_pkg::tail_t tail;
  logic              buf_free;
  logic              proc;

  // Resolve the held beat once the buffer is empty or sends its last result now
  assign proc      = in_valid_r && buf_free;
  // Take a new beat whenever the input register is empty or drains this cycle
  assign in_ready  = !in_valid_r || proc;
  assign cfg_ready = 1'b1;

  ssplit_core #(
    .DELIM_MAX (DELIM_MAX)
  ) u_core (
    .split_mode   (split_mode_r),
    .delim_length (delim_length_r),
    .delim_bytes  (delim_bytes_r),
    .win          (win_r),
    .fill         (fill_r),
    .seg_has      (seg_has_r),
    .cbl          (cbl_r),
    .data_byte    (data_byte_r),
    .byte_present (byte_present_r),
    .string_end   (string_end_r),
    .seq          (seq),
    .nb           (nb),
    .tail         (tail),
    .win_nxt      (win_nxt),
    .fill_nxt     (fill_nxt),
    .seg_has_nxt  (seg_has_nxt),
    .cbl_nxt      (cbl_nxt)
  );

  ssplit_outbuf #(
    .DELIM_MAX (DELIM_MAX)
  ) u_outbuf (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (proc),
    .seq_in          (seq),
    .nb_in           (nb),
    .tail_in         (tail),
    .free            (buf_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_segment_end (out_segment_end),
    .out_string_done (out_string_done)
  );

  // Control state: configuration, input-register valid, window fill and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_mode_r   <= 1'b0;
      delim_length_r <= 4'd0;
      delim_bytes_r  <= 64'd0;
      in_valid_r     <= 1'b0;
      fill_r         <= '0;
      seg_has_r      <= 1'b0;
      cbl_r          <= 3'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ssplit_pkg::REG_SPLIT_MODE:   split_mode_r   <= cfg_data[0];
          ssplit_pkg::REG_DELIM_LENGTH: delim_length_r <= cfg_data[3:0];
          ssplit_pkg::REG_DELIM_BYTES:  delim_bytes_r  <= cfg_data;
          default: ; // drop writes beyond the register list
        endcase
      end
      if (in_valid && in_ready) begin
        in_valid_r <= 1'b1;
      end else if (proc) begin
        in_valid_r <= 1'b0;
      end
      if (proc) begin
        fill_r    <= fill_nxt;
        seg_has_r <= seg_has_nxt;
        cbl_r     <= cbl_nxt;
      end
    end
  end

  // Payload: held beat and window bytes (bytes past the fill are never read)
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_byte_r    <= in_data_byte;
      byte_present_r <= in_byte_present;
      string_end_r   <= in_string_end;
    end
    if (proc) begin
      win_r <= win_nxt;
    end
  end

`ifndef SYNTHESIS
  // Window never holds more bytes than it has room for
  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(DELIM_MAX))
    else $error("match window overfilled");

  // A character never has more than three bytes left to come
  assert property (@(posedge clk) disable iff (!rst_n)
    cbl_r <= 3'd3)
    else $error("UTF-8 byte count out of range");

  // While the last beat of a string leaves, the split state is already clear
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_string_done) |-> (fill_r == '0 && !seg_has_r && cbl_r == 3'd0))
    else $error("state not cleared at string end");

  // A held beat is resolved at once when the result buffer is empty
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_valid) |=> !in_valid_r || $past(in_valid && in_ready))
    else $error("held beat not resolved while buffer idle");
`endif

endmodule

// ===== tb/tb_string_delimiter_splitter.sv =====
// Testbench for the string delimiter splitter: predicts segment beats and checks them.
`timescale 1ns / 1ps

module tb_string_delimiter_splitter;

  localparam int unsigned WIN_DEPTH   = 8;          // window depth the block is built with
  localparam int unsigned SETTLE      = 16;         // cycles to let a burst fully drain
  localparam int unsigned RAND_ITEMS  = 150;        // random input beats to aim for
  localparam logic [1:0]  REG_SPARE   = 2'd3;       // index with no register behind it
  localparam logic [7:0]  CH_COMMA    = 8'h2C;
  localparam logic [7:0]  CH_SPACE    = 8'h20;

  // One result beat as the block should send it
  typedef struct {
    logic [7:0] data;
    logic       data_valid;
    logic       seg_end;
    logic       done;
  } seg_beat_t;

  // Tracks the splitter's state and config, turns each accepted input beat into
  // the result beats it must produce, and checks results against them in order.
  class split_tracker;
    logic        mode;
    logic [3:0]  delim_nbytes;
    logic [63:0] delim;
    logic [7:0]  window [WIN_DEPTH];
    int unsigned fill;
    bit          seg_has_bytes;
    logic [2:0]  char_left;
    seg_beat_t   expected_beats [$];
    seg_beat_t   burst [$];
    int unsigned mismatches;
    int unsigned beats_checked;

    function new();
      mode          = ssplit_pkg::MODE_DELIM;
      delim_nbytes  = '0;
      delim         = '0;
      mismatches    = 0;
      beats_checked = 0;
      wipe_state();
    endfunction

    function void wipe_state();
      foreach (window[i]) window[i] = '0;
      fill          = 0;
      seg_has_bytes = 0;
      char_left     = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        ssplit_pkg::REG_SPLIT_MODE:   mode = val[0];
        ssplit_pkg::REG_DELIM_LENGTH: delim_nbytes = val[3:0];
        ssplit_pkg::REG_DELIM_BYTES:  delim = val;
        default: ;
      endcase
    endfunction

    // Delimiter length in use after saturation
    function int unsigned eff_len();
      int unsigned cap;
      cap = (WIN_DEPTH < ssplit_pkg::DELIM_REG_BYTES) ? WIN_DEPTH : ssplit_pkg::DELIM_REG_BYTES;
      return (delim_nbytes > cap) ? cap : int'(delim_nbytes);
    endfunction

    function void emit(logic [7:0] b, logic bv, logic se);
      if (burst.size() < ssplit_pkg::MAX_RES) burst.push_back('{b, bv, se, 1'b0});
    endfunction

    function bit is_prefix(int unsigned len);
      if (fill > len) return 0;
      for (int i = 0; i < fill; i++) begin
        if (window[i] != delim[8*i +: 8]) return 0;
      end
      return 1;
    endfunction

    // Pass the oldest window byte on as a segment byte
    function void shift_out();
      if (fill == 0) return;
      emit(window[0], 1'b1, 1'b0);
      seg_has_bytes = 1;
      for (int i = 1; i < fill; i++) window[i-1] = window[i];
      fill--;
    endfunction

    function logic [2:0] follow_bytes(logic [7:0] lead);
      if (lead < ssplit_pkg::UTF8_TWO_MIN) return 3'd0;
      if (lead < ssplit_pkg::UTF8_THREE_MIN) return 3'd1;
      if (lead < ssplit_pkg::UTF8_FOUR_MIN) return 3'd2;
      return 3'd3;
    endfunction

    function void note_item(logic [7:0] b, logic present, logic ends);
      int unsigned len;
      burst.delete();
      if (mode == ssplit_pkg::MODE_UTF8) begin
        if (present) begin
          emit(b, 1'b1, 1'b0);
          if (char_left == 0) char_left = follow_bytes(b);
          else char_left--;
          if (char_left == 0) emit(8'h00, 1'b0, 1'b1);
        end
        if (ends && char_left != 0) emit(8'h00, 1'b0, 1'b1);
      end else begin
        len = eff_len();
        if (present) begin
          if (fill >= WIN_DEPTH) shift_out();
          window[fill] = b;
          fill++;
          while (fill > 0 && !is_prefix(len)) shift_out();
          if (len > 0 && fill == len) begin
            emit(8'h00, 1'b0, 1'b1);
            fill          = 0;
            seg_has_bytes = 0;
          end
        end
        if (ends) begin
          while (fill > 0) shift_out();
          if (len == 0 || seg_has_bytes) emit(8'h00, 1'b0, 1'b1);
        end
      end
      if (ends) begin
        if (burst.size() == 0) emit(8'h00, 1'b0, 1'b0);
        burst[burst.size()-1].done = 1'b1;
        wipe_state();
      end
      foreach (burst[i]) expected_beats.push_back(burst[i]);
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      $display("[%0t] beat %0d: %s", $time, beats_checked, what);
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) flag_mismatch($sformatf("%s got %02h want %02h", name, got, want));
    endtask

    task check_beat(logic [7:0] b, logic bv, logic se, logic sd);
      seg_beat_t want;
      if (expected_beats.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat byte=%02h bv=%0b seg_end=%0b done=%0b",
                                b, bv, se, sd));
      end else begin
        want = expected_beats.pop_front();
        compare_field("out_byte", b, want.data);
        compare_field("out_byte_valid", {7'd0, bv}, {7'd0, want.data_valid});
        compare_field("out_segment_end", {7'd0, se}, {7'd0, want.seg_end});
        compare_field("out_string_done", {7'd0, sd}, {7'd0, want.done});
      end
      beats_checked++;
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_byte_present;
  logic        in_string_end;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_segment_end;
  logic        out_string_done;

  split_tracker sb;
  logic [7:0]   text_q [$];     // bytes of the next string to send
  int unsigned  items_sent;
  int unsigned  in_idle_pct;
  int unsigned  out_idle_pct;

  string_delimiter_splitter #(.DELIM_MAX(WIN_DEPTH)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_byte_present (in_byte_present),
    .in_string_end   (in_string_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_segment_end (out_segment_end),
    .out_string_done (out_string_done)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs; sized well past the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: stall at random, and check every beat taken at an edge. Both
  // out_ready and the outputs are read before this edge's updates land.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      sb.check_beat(out_byte, out_byte_valid, out_segment_end, out_string_done);
    end
  end

  // Offer one input beat and hold it until taken. Valid stays high on return so
  // a back-to-back beat never drops it; the next call lowers it only for a gap.
  task automatic send_item(input logic [7:0] b, input logic present, input logic ends);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= b;
    in_byte_present <= present;
    in_string_end   <= ends;
    do @(posedge clk); while (!in_ready);
    sb.note_item(b, present, ends);
    if (present || ends) items_sent++;
  endtask

  // Drop valid, wait for every expected beat, then let any silent work finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  // Reconfigure only once the block has gone quiet
  task automatic program_regs(input logic m, input logic [3:0] len, input logic [63:0] bytes,
                              input bit poke_spare);
    drain();
    write_reg(ssplit_pkg::REG_SPLIT_MODE, {63'd0, m});
    write_reg(ssplit_pkg::REG_DELIM_LENGTH, {60'd0, len});
    write_reg(ssplit_pkg::REG_DELIM_BYTES, bytes);
    if (poke_spare) write_reg(REG_SPARE, {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  // Send text_q as one string: end flag on the last byte, or a separate end-only beat
  task automatic send_text(input bit end_only, input bit noops);
    bit tail_only;
    tail_only = end_only || (text_q.size() == 0);
    foreach (text_q[i]) begin
      if (noops && $urandom_range(19) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(text_q[i], 1'b1, !tail_only && (i == text_q.size() - 1));
    end
    if (tail_only) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  function automatic logic [7:0] alpha_byte();
    case ($urandom_range(0, 2))
      0:       return 8'h61;
      1:       return 8'h62;
      default: return CH_COMMA;
    endcase
  endfunction

  // Byte biased toward the delimiter so partial and full matches are common
  function automatic logic [7:0] pick_byte(int unsigned len);
    int unsigned r;
    int unsigned idx;
    r = $urandom_range(0, 9);
    if (r < 5 && len > 0) begin
      idx = $urandom_range(0, len - 1);
      return sb.delim[8*idx +: 8];
    end
    if (r < 8) return alpha_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Runs of filler broken up by whole delimiters and partial prefixes
  function automatic void build_delim_text();
    int unsigned len;
    int unsigned cut;
    len = sb.eff_len();
    text_q.delete();
    repeat ($urandom_range(0, 5)) begin
      repeat ($urandom_range(0, 3)) text_q.push_back(pick_byte(len));
      case ($urandom_range(0, 3))
        0, 1: for (int i = 0; i < len; i++) text_q.push_back(sb.delim[8*i +: 8]);
        2: begin
          cut = (len > 0) ? $urandom_range(0, len - 1) : 0;
          for (int i = 0; i < cut; i++) text_q.push_back(sb.delim[8*i +: 8]);
        end
        default: ;
      endcase
    end
  endfunction

  function automatic void build_noise_text();
    text_q.delete();
    repeat ($urandom_range(0, 8)) text_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Well-formed characters of every size, sometimes cut short at the end
  function automatic void build_utf8_text();
    logic [7:0]  lead;
    int unsigned follow;
    text_q.delete();
    repeat ($urandom_range(0, 5)) begin
      follow = $urandom_range(0, 3);
      case (follow)
        0:       lead = 8'($urandom_range(0, 8'h7F));
        1:       lead = 8'($urandom_range(8'h80, 8'hDF));
        2:       lead = 8'($urandom_range(8'hE0, 8'hEF));
        default: lead = 8'($urandom_range(8'hF0, 8'hFF));
      endcase
      text_q.push_back(lead);
      repeat (follow) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
    end
    if (text_q.size() > 0 && $urandom_range(0, 4) == 0) begin
      text_q.push_back(8'($urandom_range(8'hE0, 8'hFF)));
    end
  endfunction

  initial begin
    logic        m;
    logic [3:0]  len;
    logic [63:0] bytes;
    int unsigned goal;

    sb           = new();
    items_sent   = 0;
    in_idle_pct  = 21;
    out_idle_pct = 57;
    rst_n           <= 1'b0;
    cfg_valid       <= 1'b0;
    cfg_index       <= ssplit_pkg::REG_SPLIT_MODE;
    cfg_data        <= '0;
    in_valid        <= 1'b0;
    in_data_byte    <= '0;
    in_byte_present <= 1'b0;
    in_string_end   <= 1'b0;
    out_ready       <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset config means an empty delimiter: bytes pass, one segment per string
    text_q = '{8'hFF, 8'h00};
    send_text(0, 0);
    send_item(8'h00, 1'b0, 1'b1);   // empty string still closes one segment
    send_item(8'hA5, 1'b0, 1'b0);   // no-op beat, nothing comes back

    // Two-byte delimiter: empty first and middle segments, a partial match left
    // at the end, then an empty last segment dropped
    program_regs(ssplit_pkg::MODE_DELIM, 4'd2, {48'd0, CH_SPACE, CH_COMMA}, 1);
    text_q = '{CH_COMMA, CH_SPACE, CH_COMMA, CH_SPACE, 8'h78, CH_COMMA};
    send_text(0, 0);
    text_q = '{8'h62, CH_COMMA, CH_SPACE};
    send_text(0, 0);

    // Delimiter swapped mid-string: the held byte no longer fits and is flushed
    send_item(CH_COMMA, 1'b1, 1'b0);
    program_regs(ssplit_pkg::MODE_DELIM, 4'd1, 64'h78, 0);
    send_item(8'h79, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);

    // Over-long length saturates; partial match flushed by an end-only beat
    program_regs(ssplit_pkg::MODE_DELIM, 4'd12, 64'hFF00_FF00_FF00_FF00, 0);
    text_q = '{8'h00, 8'hFF};
    send_text(1, 0);

    // Character mode: one, three, stray continuation as a two-byte lead,
    // then a four-byte lead cut short by the string end
    program_regs(ssplit_pkg::MODE_UTF8, 4'd0, 64'd0, 0);
    text_q = '{8'h41, 8'hE2, 8'h82, 8'hAC, 8'h80, 8'h00, 8'hF0};
    send_text(0, 0);

    // Random part in three idling regimes
    for (int ph = 0; ph < 3; ph++) begin
      drain();
      case (ph)
        0: begin in_idle_pct = 21; out_idle_pct = 57; end
        1: begin in_idle_pct = 57; out_idle_pct = 21; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      goal = items_sent + RAND_ITEMS / 3;
      while (items_sent < goal) begin
        m = ($urandom_range(0, 3) == 0) ? ssplit_pkg::MODE_UTF8 : ssplit_pkg::MODE_DELIM;
        case ($urandom_range(0, 9))
          0:       len = 4'd0;
          1:       len = 4'd8;
          2:       len = 4'($urandom_range(9, 15));
          default: len = 4'($urandom_range(1, 3));
        endcase
        for (int i = 0; i < 8; i++) begin
          bytes[8*i +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                        : alpha_byte();
        end
        program_regs(m, len, bytes, 0);
        repeat ($urandom_range(2, 4)) begin
          if (m == ssplit_pkg::MODE_UTF8) build_utf8_text();
          else if ($urandom_range(0, 6) == 0) build_noise_text();
          else build_delim_text();
          send_text($urandom_range(0, 3) == 0, 1);
        end
      end
    end

    drain();
    if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
